// ===== rtl/cdl_pkg.sv =====
package cdl_pkg;

    localparam int GRID_WIDTH_DEF = 64;
    localparam int NUM_SPECIES    = 6;
    localparam int SPECIES_W      = 3;
    localparam int COORD_IN_W     = 6;
    localparam int COORD_SPAN     = 64;
    localparam int RAND_W         = 16;
    localparam int OUTC_W         = 3;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    typedef logic [SPECIES_W-1:0] species_t;
    typedef logic [OUTC_W-1:0]    outcome_t;

    // request action codes, the unused code behaves as a read
    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic [1:0] DIR_ROW_UP   = 2'd0;
    localparam logic [1:0] DIR_COL_UP   = 2'd1;
    localparam logic [1:0] DIR_ROW_DOWN = 2'd2;
    localparam logic [1:0] DIR_COL_DOWN = 2'd3;

    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_INVADE_B = 2'd1;
    localparam logic [1:0] KIND_SWAP     = 2'd2;
    localparam logic [1:0] KIND_INVADE_A = 2'd3;

    localparam outcome_t OUTC_NONE      = 3'd0;
    localparam outcome_t OUTC_INVADED_B = 3'd1;
    localparam outcome_t OUTC_SWAPPED   = 3'd2;
    localparam outcome_t OUTC_INVADED_A = 3'd3;
    localparam outcome_t OUTC_REFUSED   = 3'd4;

    localparam int REG_SWAP_THRESHOLD = 0;
    localparam logic signed [RAND_W-1:0] SWAP_THRESHOLD_RST = 16'sd2048;

    // payoff on (chosen species, neighbor species)
    localparam logic [1:0] PAYOFF_TAB [NUM_SPECIES][NUM_SPECIES] = '{
        '{2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd3},
        '{2'd3, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3},
        '{2'd3, 2'd3, 2'd0, 2'd1, 2'd1, 2'd2},
        '{2'd2, 2'd3, 2'd3, 2'd0, 2'd1, 2'd1},
        '{2'd1, 2'd2, 2'd3, 2'd3, 2'd0, 2'd1},
        '{2'd1, 2'd1, 2'd2, 2'd3, 2'd3, 2'd0}
    };

    function automatic logic [1:0] payoff_kind(species_t s1, species_t s2);
        logic [1:0] k;
        if (s1 < species_t'(NUM_SPECIES) && s2 < species_t'(NUM_SPECIES))
            k = PAYOFF_TAB[s1][s2];
        else
            k = KIND_NONE;
        return k;
    endfunction

    typedef struct packed {
        logic rd_en;
        logic we_a;
        logic we_b;
    } mem_ctrl_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

// ===== rtl/cdl_if.sv =====
interface cdl_in_if;
    import cdl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               action;
    logic [COORD_IN_W-1:0]    row;
    logic [COORD_IN_W-1:0]    col;
    logic [1:0]               direction;
    logic signed [RAND_W-1:0] rand_val;
    logic [SPECIES_W-1:0]     new_species;

    modport source (
        output valid, action, row, col, direction, rand_val, new_species,
        input  ready
    );
    modport sink (
        input  valid, action, row, col, direction, rand_val, new_species,
        output ready
    );
endinterface

interface cdl_out_if;
    import cdl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [SPECIES_W-1:0] first_species;
    logic [SPECIES_W-1:0] second_species;
    logic [OUTC_W-1:0]    outcome;

    modport source (
        output valid, first_species, second_species, outcome,
        input  ready
    );
    modport sink (
        input  valid, first_species, second_species, outcome,
        output ready
    );
endinterface

// ===== rtl/cdl_regs.sv =====
module cdl_regs
    import cdl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready,
    output logic signed [RAND_W-1:0] swap_threshold
);

    logic signed [RAND_W-1:0] thr_reg;
    logic signed [RAND_W-1:0] thr_next;
    logic                     hit;

    // one register, so the word index is the top address bit
    assign hit = (paddr[APB_AW-1] == 1'(REG_SWAP_THRESHOLD));

    always_comb
    begin
        thr_next = thr_reg;
        if (psel && penable && pwrite && hit)
            thr_next = pwdata[RAND_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= SWAP_THRESHOLD_RST;
        else
            thr_reg <= thr_next;
    end

    assign prdata         = hit ? {{(APB_DW-RAND_W){thr_reg[RAND_W-1]}}, thr_reg} : '0;
    assign pready         = 1'b1;
    assign swap_threshold = thr_reg;

endmodule

// ===== rtl/cdl_grid_mem.sv =====
module cdl_grid_mem
    import cdl_pkg::*;
#(
    parameter int DEPTH = GRID_WIDTH_DEF * GRID_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  mem_ctrl_t     ctrl,
    input  logic [AW-1:0] addr_a,
    input  logic [AW-1:0] addr_b,
    input  species_t      wd_a,
    input  species_t      wd_b,
    output species_t      rd_a,
    output species_t      rd_b
);

    species_t grid_mem [DEPTH];
    species_t rd_a_reg;
    species_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.we_a)
            grid_mem[addr_a] <= wd_a;
        if (ctrl.we_b)
            grid_mem[addr_b] <= wd_b;
        if (ctrl.rd_en)
        begin
            rd_a_reg <= grid_mem[addr_a];
            rd_b_reg <= grid_mem[addr_b];
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

// ===== rtl/cdl_engine.sv =====
module cdl_engine
    import cdl_pkg::*;
#(
    parameter int GRID_WIDTH = GRID_WIDTH_DEF,
    parameter int AW         = $clog2(GRID_WIDTH * GRID_WIDTH)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    cdl_in_if.sink                   req,
    cdl_out_if.source                rsp,
    input  logic signed [RAND_W-1:0] swap_threshold,
    output mem_ctrl_t                ctrl,
    output logic [AW-1:0]            addr_a,
    output logic [AW-1:0]            addr_b,
    output species_t                 wd_a,
    output species_t                 wd_b,
    input  species_t                 rd_a,
    input  species_t                 rd_b
);

    localparam int CW = $clog2(GRID_WIDTH);

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   accept;
    logic   load;

    logic [1:0]               action_reg;
    logic signed [RAND_W-1:0] rand_reg;
    species_t                 species_reg;
    logic [AW-1:0]            addr_a_reg;
    logic [AW-1:0]            addr_b_reg;
    species_t                 first_reg, first_next;
    species_t                 second_reg, second_next;
    outcome_t                 outcome_reg, outcome_next;

    logic [CW-1:0] wrap_lut [COORD_SPAN];
    logic [CW-1:0] r1, c1, r2, c2;
    logic [CW-1:0] r_up, r_dn, c_up, c_dn;
    logic [AW-1:0] addr_a_in, addr_b_in;
    species_t      species_in;
    logic [1:0]    kind;
    logic          swap_ok;

    // coordinate reduction table, built at elaboration
    for (genvar i = 0; i < COORD_SPAN; i++)
    begin : g_wrap
        assign wrap_lut[i] = CW'(i % GRID_WIDTH);
    end

    always_comb
    begin
        r1   = wrap_lut[req.row];
        c1   = wrap_lut[req.col];
        r_up = (r1 == CW'(GRID_WIDTH - 1)) ? '0 : r1 + 1'b1;
        r_dn = (r1 == '0) ? CW'(GRID_WIDTH - 1) : r1 - 1'b1;
        c_up = (c1 == CW'(GRID_WIDTH - 1)) ? '0 : c1 + 1'b1;
        c_dn = (c1 == '0) ? CW'(GRID_WIDTH - 1) : c1 - 1'b1;
        r2   = r1;
        c2   = c1;
        case (req.direction)
            DIR_ROW_UP:   r2 = r_up;
            DIR_COL_UP:   c2 = c_up;
            DIR_ROW_DOWN: r2 = r_dn;
            DIR_COL_DOWN: c2 = c_dn;
            default:      r2 = r1;
        endcase
        addr_a_in  = AW'(r1) * AW'(GRID_WIDTH) + AW'(c1);
        addr_b_in  = AW'(r2) * AW'(GRID_WIDTH) + AW'(c2);
        species_in = (req.new_species > species_t'(NUM_SPECIES - 1)) ?
                     species_t'(NUM_SPECIES - 1) : req.new_species;
    end

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign kind    = payoff_kind(rd_a, rd_b);
    assign swap_ok = (rand_reg < swap_threshold);

    // memory ports read at accept, write back from the registered addresses
    assign addr_a = (state_reg == S_IDLE) ? addr_a_in : addr_a_reg;
    assign addr_b = (state_reg == S_IDLE) ? addr_b_in : addr_b_reg;

    always_comb
    begin
        state_next   = state_reg;
        ov_next      = ov_reg && !rsp.ready;
        ctrl         = '0;
        wd_a         = rd_b;
        wd_b         = rd_a;
        load         = 1'b0;
        first_next   = first_reg;
        second_next  = second_reg;
        outcome_next = outcome_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctrl.rd_en = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold the cells until the result slot frees up
                if (!ov_reg || rsp.ready)
                begin
                    load         = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                    first_next   = rd_a;
                    second_next  = '0;
                    outcome_next = OUTC_NONE;
                    case (action_reg)
                        ACT_WRITE:
                        begin
                            ctrl.we_a  = 1'b1;
                            wd_a       = species_reg;
                            first_next = species_reg;
                        end
                        ACT_UPDATE:
                        begin
                            second_next = rd_b;
                            case (kind)
                                KIND_INVADE_B:
                                begin
                                    ctrl.we_b    = 1'b1;
                                    wd_b         = rd_a;
                                    second_next  = rd_a;
                                    outcome_next = OUTC_INVADED_B;
                                end
                                KIND_INVADE_A:
                                begin
                                    ctrl.we_a    = 1'b1;
                                    wd_a         = rd_b;
                                    first_next   = rd_b;
                                    outcome_next = OUTC_INVADED_A;
                                end
                                KIND_SWAP:
                                begin
                                    if (swap_ok)
                                    begin
                                        ctrl.we_a    = 1'b1;
                                        ctrl.we_b    = 1'b1;
                                        first_next   = rd_b;
                                        second_next  = rd_a;
                                        outcome_next = OUTC_SWAPPED;
                                    end
                                    else
                                    begin
                                        outcome_next = OUTC_REFUSED;
                                    end
                                end
                                default: outcome_next = OUTC_NONE;
                            endcase
                        end
                        ACT_READ: first_next = rd_a;
                        default:  first_next = rd_a;
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg  <= req.action;
            rand_reg    <= req.rand_val;
            species_reg <= species_in;
            addr_a_reg  <= addr_a_in;
            addr_b_reg  <= addr_b_in;
        end
        if (load)
        begin
            first_reg   <= first_next;
            second_reg  <= second_next;
            outcome_reg <= outcome_next;
        end
    end

    assign rsp.valid          = ov_reg;
    assign rsp.first_species  = first_reg;
    assign rsp.second_species = second_reg;
    assign rsp.outcome        = outcome_reg;

`ifndef ASSERT_OFF
    a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted request did not enter execute");

    a_write_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.we_a || ctrl.we_b) |-> (state_reg == S_EXEC && (!ov_reg || rsp.ready)))
        else $error("grid written outside execute or with result slot full");

    a_distinct_cells: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.we_a && ctrl.we_b) |-> (addr_a_reg != addr_b_reg))
        else $error("both ports write the same cell");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg == S_EXEC))
        else $error("result appeared without an execute cycle");
`endif

endmodule

// ===== rtl/cyclic_dominance_lattice_update.sv =====
// six-species cyclic dominance lattice, one cell action per request
// req channel: action (0 write, 1 update, 2 or 3 read), row, col, direction,
// rand_val and new_species; accepted when valid and ready are both high
// rsp channel: first_species, second_species and outcome, one result per request
// an update reads the chosen cell and its wrapping neighbor through the two ports
// of the grid memory, looks up the payoff table and writes back either cell, both
// or neither; the grid memory is read in the accept cycle and written back in the
// execute state, which also loads the result into the output register; a new
// request is not taken until the last one leaves the execute state
// while the receiver stalls the result stays in its output register; a following
// request is still accepted, and its execute cycle waits until the result is taken
// the user writes swap_threshold over the apb port only while the block is idle,
// which the block does not enforce; reset clears the control state and loads
// swap_threshold with 2048; the grid contents are not cleared and a cell must be
// written before it is read
module cyclic_dominance_lattice_update
    import cdl_pkg::*;
#(
    parameter int GRID_WIDTH = GRID_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    cdl_in_if.sink            req,
    cdl_out_if.source         rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int DEPTH = GRID_WIDTH * GRID_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    logic signed [RAND_W-1:0] swap_threshold;
    mem_ctrl_t                ctrl;
    logic [AW-1:0]            addr_a, addr_b;
    species_t                 wd_a, wd_b, rd_a, rd_b;

    cdl_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .swap_threshold (swap_threshold)
    );

    cdl_grid_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_grid_mem (
        .clk    (clk),
        .ctrl   (ctrl),
        .addr_a (addr_a),
        .addr_b (addr_b),
        .wd_a   (wd_a),
        .wd_b   (wd_b),
        .rd_a   (rd_a),
        .rd_b   (rd_b)
    );

    cdl_engine #(
        .GRID_WIDTH (GRID_WIDTH),
        .AW         (AW)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .rsp            (rsp),
        .swap_threshold (swap_threshold),
        .ctrl           (ctrl),
        .addr_a         (addr_a),
        .addr_b         (addr_b),
        .wd_a           (wd_a),
        .wd_b           (wd_b),
        .rd_a           (rd_a),
        .rd_b           (rd_b)
    );

endmodule
